// ----- hw/rtl/asa_pkg.sv -----
// Shared constants, command and status codes and the controller/datapath
// interface types of the aligned stack allocator. No dependencies.
`default_nettype none

package asa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 12;
    localparam int OFFSET_BITS  = 24;
    localparam int ALIGN_MAX    = 12;

    localparam logic [2:0] CMD_ALLOC    = 3'd0;
    localparam logic [2:0] CMD_REL_LAST = 3'd1;
    localparam logic [2:0] CMD_REL_MARK = 3'd2;
    localparam logic [2:0] CMD_CLEAR    = 3'd3;
    localparam logic [2:0] CMD_GET_MARK = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_POOL = 1'b1;

    typedef struct packed {
        logic       load_in;
        logic       clear;
        logic       alc1;
        logic       alc2;
        logic       commit;
        logic       pop_top;
        logic       pop_only;
        logic       mk_load;
        logic       set_mark;
        logic       emit;
        logic [1:0] status;
        logic       use_blk;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_req;
        logic full;
        logic fit;
        logic empty;
        logic mark_bad;
        logic pop_more;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/asa_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module asa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/asa_ctrl.sv -----
// Controller state machine of the aligned stack allocator: sequences each
// command through the datapath. Depends on asa_pkg.
`default_nettype none

module asa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    input  wire logic [2:0]       i_cmd,
    output logic                  o_s_ready,
    input  wire asa_pkg::t_dp_sts i_sts,
    output asa_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALC1,
        S_ALC2,
        S_ALC3,
        S_POP1,
        S_POP2,
        S_MK1,
        S_MK2,
        S_MK3,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [1:0] r_stat;
    logic       r_use_blk;
    logic       w_accept;

    assign o_s_ready = (r_state == S_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.status  = r_stat;
        o_cmd.use_blk = r_use_blk;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in = w_accept;
                o_cmd.clear   = w_accept && (i_cmd == asa_pkg::CMD_CLEAR);
            end
            S_ALC1: o_cmd.alc1 = 1'b1;
            S_ALC2: o_cmd.alc2 = 1'b1;
            S_ALC3: o_cmd.commit = i_sts.fit;
            S_POP2: o_cmd.pop_top = 1'b1;
            S_MK1:  o_cmd.mk_load = 1'b1;
            S_MK2:  o_cmd.set_mark = i_sts.empty;
            S_MK3: begin
                o_cmd.pop_only = i_sts.pop_more;
                o_cmd.set_mark = !i_sts.pop_more;
            end
            S_EMIT: o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stat    <= asa_pkg::ST_OK;
            r_use_blk <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_use_blk <= 1'b0;
                        r_stat    <= asa_pkg::ST_OK;
                        case (i_cmd)
                            asa_pkg::CMD_ALLOC:    r_state <= S_ALC1;
                            asa_pkg::CMD_REL_LAST: r_state <= S_POP1;
                            asa_pkg::CMD_REL_MARK: r_state <= S_MK1;
                            asa_pkg::CMD_CLEAR:    r_state <= S_EMIT;
                            asa_pkg::CMD_GET_MARK: r_state <= S_EMIT;
                            default: begin
                                r_stat  <= asa_pkg::ST_BAD;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_ALC1: begin
                    if (i_sts.bad_req) begin
                        r_stat  <= asa_pkg::ST_BAD;
                        r_state <= S_EMIT;
                    end else if (i_sts.full) begin
                        r_stat  <= asa_pkg::ST_FULL;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_ALC2;
                    end
                end
                S_ALC2: r_state <= S_ALC3;
                S_ALC3: begin
                    if (i_sts.fit) begin
                        r_stat    <= asa_pkg::ST_OK;
                        r_use_blk <= 1'b1;
                    end else begin
                        r_stat <= asa_pkg::ST_NO_SPACE;
                    end
                    r_state <= S_EMIT;
                end
                S_POP1: begin
                    if (i_sts.empty) begin
                        r_stat  <= asa_pkg::ST_BAD;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_POP2;
                    end
                end
                S_POP2: r_state <= S_EMIT;
                S_MK1: begin
                    if (i_sts.mark_bad) begin
                        r_stat  <= asa_pkg::ST_BAD;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MK2;
                    end
                end
                S_MK2: begin
                    if (i_sts.empty) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MK3;
                    end
                end
                S_MK3: begin
                    if (i_sts.pop_more) begin
                        r_state <= S_MK2;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/asa_dp.sv -----
// Datapath of the aligned stack allocator: top offset, block count, stack of
// block starts, allocation arithmetic and result register.
// Depends on asa_pkg and asa_ram.
`default_nettype none

module asa_dp #(
    parameter int MAX_BLOCKS   = asa_pkg::MAX_BLOCKS,
    parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES,
    parameter int OFFSET_BITS  = asa_pkg::OFFSET_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [31:0]      i_base,
    input  wire logic [23:0]      i_pool,
    input  wire logic [23:0]      i_req,
    input  wire logic [3:0]       i_alg,
    input  wire logic [31:0]      i_mark,
    input  wire asa_pkg::t_dp_cmd i_cmd,
    output asa_pkg::t_dp_sts      o_sts,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [1:0]            o_status,
    output logic [31:0]           o_block_address,
    output logic [31:0]           o_top_address,
    output logic [23:0]           o_used_bytes
);

    localparam int OW = OFFSET_BITS;
    localparam int NW = ((OFFSET_BITS > 24) ? OFFSET_BITS : 24) + 2;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(MAX_BLOCKS);

    logic [OW-1:0] r_top;
    logic [CW-1:0] r_count;
    logic [23:0]   r_req;
    logic [3:0]    r_alg;
    logic [31:0]   r_mark;
    logic [NW-1:0] r_thr;
    logic [31:0]   r_hdr;
    logic [11:0]   r_pad;
    logic [NW-1:0] r_newtop;
    logic [31:0]   r_blk;
    logic [31:0]   r_moff;
    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [31:0]   r_oblk;
    logic [31:0]   r_otop;
    logic [23:0]   r_oused;

    logic [CW-1:0] w_cnt_m1;
    logic [OW-1:0] w_rdata;
    logic [11:0]   w_amask;
    logic [11:0]   w_hlo;
    logic [11:0]   w_pad;
    logic [NW-1:0] w_pool;
    logic [NW-1:0] w_offmask;
    logic [NW-1:0] w_cap;
    logic [31:0]   w_moff;
    logic          w_out_free;

    assign w_cnt_m1  = r_count - CW'(1);
    assign w_amask   = 12'((13'd1 << r_alg) - 13'd1);
    assign w_hlo     = 12'(i_base) + 12'(r_top) + 12'(HEADER_BYTES);
    assign w_pad     = (12'd0 - w_hlo) & w_amask;
    assign w_pool    = NW'(i_pool);
    assign w_offmask = NW'({OW{1'b1}});
    assign w_cap     = (w_pool > w_offmask) ? w_offmask : w_pool;
    assign w_moff    = r_mark - i_base;
    assign w_out_free = !r_ovalid || i_ready;

    assign o_sts.bad_req  = (r_req == 24'd0) || (r_alg > 4'(asa_pkg::ALIGN_MAX));
    assign o_sts.full     = (r_count == CW'(MAX_BLOCKS));
    assign o_sts.fit      = (r_newtop <= w_cap);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.mark_bad = (w_moff > 32'(r_top));
    assign o_sts.pop_more = (r_count != '0) && (32'(w_rdata) >= r_moff);
    assign o_sts.out_free = w_out_free;

    asa_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (w_cnt_m1[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_top   <= '0;
                r_count <= '0;
            end else if (i_cmd.commit) begin
                r_top   <= OW'(r_newtop);
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_top) begin
                r_top   <= w_rdata;
                r_count <= w_cnt_m1;
            end else if (i_cmd.pop_only) begin
                r_count <= w_cnt_m1;
            end else if (i_cmd.set_mark) begin
                r_top <= OW'(r_moff);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req  <= i_req;
            r_alg  <= i_alg;
            r_mark <= i_mark;
        end
        if (i_cmd.alc1) begin
            r_thr <= NW'(r_top) + NW'(HEADER_BYTES) + NW'(r_req);
            r_hdr <= i_base + 32'(r_top) + 32'(HEADER_BYTES);
            r_pad <= w_pad;
        end
        if (i_cmd.alc2) begin
            r_newtop <= r_thr + NW'(r_pad);
            r_blk    <= r_hdr + 32'(r_pad);
        end
        if (i_cmd.mk_load) begin
            r_moff <= w_moff;
        end
        if (i_cmd.emit) begin
            r_ostatus <= i_cmd.status;
            r_oblk    <= i_cmd.use_blk ? r_blk : 32'd0;
            r_otop    <= i_base + 32'(r_top);
            r_oused   <= 24'(r_top);
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_block_address = r_oblk;
    assign o_top_address   = r_otop;
    assign o_used_bytes    = r_oused;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("Block count exceeds the stack depth.");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !o_sts.full && o_sts.fit)
        else $error("Block pushed on a full stack or without space.");

    a_commit_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (NW'(r_top) == $past(r_newtop)))
        else $error("Top offset not moved to the end of the new block.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("Result register overwritten before its transfer.");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/aligned_stack_allocator.sv -----
// Top level of the aligned stack allocator: stream ports, configuration
// registers, controller and datapath. Depends on asa_pkg, asa_ctrl, asa_dp.
//
// Commands arrive on the slave stream, one transfer each, and every command
// gives exactly one result transfer on the master stream carrying status,
// block address, top address and used bytes after the command.
// The configuration registers (pool base address at 0x0, pool size at 0x4)
// are to be written through the APB port while the block is idle; the
// block itself does not enforce this. Clear, get mark and unknown codes go
// straight to the result; an allocate with a bad request or a full stack,
// a release last on an empty stack and a release to mark outside the used
// range stop after their first check. Allocate passes through its stages:
// one stage computes the padding, one the new top, one the space check.
// Release to mark reads one stack entry per RAM read. A new command is
// taken in the cycle after the result is loaded into the output register.
// The output register holds its result while the receiver stalls, and a
// further command is taken meanwhile; its result waits until the register
// is free. Reset empties the pool and the stack, clears both configuration
// registers and drops any pending result.
`default_nettype none

module aligned_stack_allocator #(
    parameter int MAX_BLOCKS   = asa_pkg::MAX_BLOCKS,
    parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES,
    parameter int OFFSET_BITS  = asa_pkg::OFFSET_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // request_bytes[23:0], align_log2[27:24], mark_address[59:28], zeros
    input  wire logic [63:0] i_s_axis_tdata,
    // cmd[2:0]
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status[1:0], block_address[33:2], top_address[65:34],
    // used_bytes[89:66], zeros
    output logic [95:0]      o_m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0]      r_base;
    logic [23:0]      r_pool;
    logic             w_wr;
    asa_pkg::t_dp_cmd w_cmd;
    asa_pkg::t_dp_sts w_sts;
    logic [1:0]       w_status;
    logic [31:0]      w_blk;
    logic [31:0]      w_top;
    logic [23:0]      w_used;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pool <= '0;
        end else if (w_wr) begin
            if (paddr[2] == asa_pkg::REG_BASE) begin
                r_base <= pwdata;
            end else begin
                r_pool <= pwdata[23:0];
            end
        end
    end

    assign prdata = (paddr[2] == asa_pkg::REG_POOL) ? {8'd0, r_pool} : r_base;

    asa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_cmd     (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    asa_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_base          (r_base),
        .i_pool          (r_pool),
        .i_req           (i_s_axis_tdata[23:0]),
        .i_alg           (i_s_axis_tdata[27:24]),
        .i_mark          (i_s_axis_tdata[59:28]),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_status        (w_status),
        .o_block_address (w_blk),
        .o_top_address   (w_top),
        .o_used_bytes    (w_used)
    );

    assign o_m_axis_tdata = {6'd0, w_used, w_top, w_blk, w_status};

endmodule

`default_nettype wire

// ----- tb/asa_result_checker.sv -----
// Result checker for the aligned stack allocator: watches the command, result and APB channels,
// predicts each result from its own copy of the pool state and compares it field by field.
// Depends on asa_pkg.
module asa_result_checker
    import asa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [63:0] i_s_tdata,
    input  wire logic [2:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [95:0] i_m_tdata,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]             status;
        logic [31:0]            block_addr;
        logic [31:0]            top_addr;
        logic [OFFSET_BITS-1:0] used;
    } t_alloc_reply;

    t_alloc_reply           replies_due[$];
    logic [31:0]            pool_base;
    logic [23:0]            pool_size;
    logic [OFFSET_BITS-1:0] top_off;
    logic [OFFSET_BITS-1:0] starts[MAX_BLOCKS];
    int                     depth;
    int                     fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_alloc_reply predict_reply(input logic [2:0] cmd,
            input logic [23:0] req, input logic [3:0] alg, input logic [31:0] mark);
        t_alloc_reply r;
        logic [63:0]  room;
        logic [63:0]  hdr;
        logic [63:0]  pad;
        logic [63:0]  need;
        logic [31:0]  moff;
        r.status     = ST_OK;
        r.block_addr = '0;
        case (cmd)
            CMD_ALLOC: begin
                if (req == '0 || alg > ALIGN_MAX) begin
                    r.status = ST_BAD;
                end else if (depth >= MAX_BLOCKS) begin
                    r.status = ST_FULL;
                end else begin
                    room = (top_off < pool_size) ? 64'(pool_size) - 64'(top_off) : 64'd0;
                    hdr  = 64'(pool_base) + 64'(top_off) + 64'(HEADER_BYTES);
                    pad  = (64'd0 - hdr) & ((64'd1 << alg) - 64'd1);
                    need = 64'(HEADER_BYTES) + pad + 64'(req);
                    if (need > room) begin
                        r.status = ST_NO_SPACE;
                    end else begin
                        starts[depth] = top_off;
                        depth++;
                        top_off      = OFFSET_BITS'(64'(top_off) + need);
                        r.block_addr = 32'(hdr + pad);
                    end
                end
            end
            CMD_REL_LAST: begin
                if (depth == 0) begin
                    r.status = ST_BAD;
                end else begin
                    depth--;
                    top_off = starts[depth];
                end
            end
            CMD_REL_MARK: begin
                moff = mark - pool_base;
                if (moff > 32'(top_off)) begin
                    r.status = ST_BAD;
                end else begin
                    while (depth > 0 && 32'(starts[depth-1]) >= moff)
                        depth--;
                    top_off = moff[OFFSET_BITS-1:0];
                end
            end
            CMD_CLEAR: begin
                top_off = '0;
                depth   = 0;
            end
            CMD_GET_MARK: begin
            end
            default: begin
                r.status = ST_BAD;
            end
        endcase
        r.top_addr = pool_base + 32'(top_off);
        r.used     = top_off;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_alloc_reply got;
        t_alloc_reply want;
        if (!i_rst_n) begin
            replies_due.delete();
            pool_base = '0;
            pool_size = '0;
            top_off   = '0;
            depth     = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{status: i_m_tdata[1:0], block_addr: i_m_tdata[33:2],
                        top_addr: i_m_tdata[65:34], used: i_m_tdata[89:66]};
                if (replies_due.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time,
                             i_m_tdata);
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("block address", want.block_addr, got.block_addr);
                    check_field("top address", want.top_addr, got.top_addr);
                    check_field("used bytes", 32'(want.used), 32'(got.used));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_POOL)
                    pool_size = i_pwdata[23:0];
                else
                    pool_base = i_pwdata;
            end
            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(predict_reply(i_s_tuser, i_s_tdata[23:0],
                                                    i_s_tdata[27:24], i_s_tdata[59:28]));
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/aligned_stack_allocator_test.sv -----
// Testbench top for the aligned stack allocator: clock, reset, APB set-up of the pool,
// directed and random command streams with random idling, watchdog and verdict.
// Depends on asa_pkg, aligned_stack_allocator and asa_result_checker.
module aligned_stack_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import asa_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 140;
    localparam int IDLE_PERCENT   = 12;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    logic        calm;
    logic [31:0] cur_base;
    logic [31:0] seen_tops[$];

    aligned_stack_allocator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    asa_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk) begin
        if (m_tvalid && m_tready) begin
            seen_tops.push_back(m_tdata[65:34]);
            if (seen_tops.size() > 8)
                void'(seen_tops.pop_front());
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_command(input logic [2:0] cmd, input logic [23:0] req,
            input logic [3:0] alg, input logic [31:0] mark);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'h0, mark, alg, req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_pool(input logic [31:0] base, input logic [23:0] size);
        drain();
        apb_write({REG_BASE, 2'b00}, base);
        apb_write({REG_POOL, 2'b00}, {8'h00, size});
        cur_base = base;
        seen_tops.delete();
    endtask

    function automatic logic [31:0] pick_mark();
        logic [31:0] recent;
        recent = (seen_tops.size() != 0) ?
                 seen_tops[$urandom_range(0, seen_tops.size() - 1)] : cur_base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return recent;
            4, 5:       return recent - $urandom_range(1, 40);
            6:          return cur_base;
            7:          return cur_base - 32'd1;
            8:          return $urandom;
            default:    return cur_base + $urandom_range(0, 300);
        endcase
    endfunction

    task automatic send_random_command();
        int unsigned pick;
        logic [2:0]  cmd;
        logic [23:0] req;
        logic [3:0]  alg;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            cmd = CMD_ALLOC;
        else if (pick < 62)
            cmd = CMD_REL_LAST;
        else if (pick < 75)
            cmd = CMD_REL_MARK;
        else if (pick < 81)
            cmd = CMD_CLEAR;
        else if (pick < 93)
            cmd = CMD_GET_MARK;
        else
            cmd = CMD_GET_MARK + 3'($urandom_range(1, 3));
        case ($urandom_range(0, 19))
            0:       req = '0;
            1:       req = 24'($urandom);
            2, 3:    req = 24'($urandom_range(1, 4096));
            default: req = 24'($urandom_range(1, 64));
        endcase
        if ($urandom_range(0, 9) == 0)
            alg = 4'($urandom_range(ALIGN_MAX + 1, 15));
        else
            alg = 4'($urandom_range(0, ALIGN_MAX));
        send_command(cmd, req, alg, pick_mark());
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_random_command();
    endtask

    // Small allocations back to back, enough to run the block stack over.
    task automatic fill_stack(input int count);
        repeat (count)
            send_command(CMD_ALLOC, 24'($urandom_range(1, 16)), 4'($urandom_range(0, 5)),
                         $urandom);
    endtask

    initial begin
        rst_n    = 1'b0;
        calm     = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ALLOC;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_base = '0;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        set_pool(32'h0000_1000, 24'd600);
        send_command(CMD_GET_MARK, '0, '0, '0);
        send_command(CMD_REL_LAST, '0, '0, '0);
        send_command(CMD_ALLOC, '0, '0, '0);
        send_command(CMD_ALLOC, 24'd1, 4'd13, '0);
        send_command(CMD_ALLOC, 24'd1, 4'd15, '0);
        send_command(CMD_ALLOC, 24'hFF_FFFF, '0, '0);
        send_command(CMD_ALLOC, 24'd1, '0, '0);
        send_command(CMD_ALLOC, 24'd100, 4'd4, '0);
        send_command(CMD_GET_MARK, '0, '0, '0);
        send_command(CMD_ALLOC, 24'd50, 4'd3, '0);
        send_command(CMD_ALLOC, 24'd30, '0, '0);
        send_command(CMD_REL_MARK, '0, '0, 32'h0000_1000 + 32'd600);
        send_command(CMD_REL_MARK, '0, '0, 32'h0000_0FFF);
        send_command(CMD_REL_MARK, '0, '0, 32'h0000_1000 + 32'd20);
        send_command(CMD_REL_MARK, '0, '0, 32'h0000_1000 + 32'd20);
        send_command(CMD_REL_LAST, '0, '0, '0);
        send_command(CMD_ALLOC, 24'd1, 4'(ALIGN_MAX), '0);
        send_command(CMD_GET_MARK + 3'd1, 24'hFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        send_command(CMD_GET_MARK + 3'd2, '0, '0, '0);
        send_command(CMD_GET_MARK + 3'd3, '0, '0, '0);
        send_command(CMD_ALLOC, 24'd588, '0, '0);
        send_command(CMD_ALLOC, 24'd1, '0, '0);
        send_command(CMD_CLEAR, '0, '0, '0);
        send_command(CMD_GET_MARK, '0, '0, '0);

        calm = 1'b1;
        set_pool(32'h0000_0000, 24'hFF_FFFF);
        fill_stack(70);
        run_random(60);
        drain();
        calm = 1'b0;

        set_pool(32'hFFFF_F800, 24'd4000);
        run_random(150);

        set_pool($urandom, 24'($urandom_range(0, 3000)));
        run_random(150);

        set_pool(32'hFFFF_FFFF, 24'd0);
        run_random(60);

        set_pool($urandom & 32'hFFFF_F000, 24'hFF_FFFF);
        fill_stack(70);
        run_random(50);

        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
